>>> rtl/wall_pair_force_energy_core_macros.svh
// Assertion macros shared by the wall pair force and energy core.
`ifndef WALL_PAIR_FORCE_ENERGY_CORE_MACROS_SVH
`define WALL_PAIR_FORCE_ENERGY_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WPFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds a fixed number of cycles after the antecedent.
`define WPFE_ASSERT_AFTER(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

>>> rtl/wpfe_pkg.sv
// Package with the types, constants and pipeline depths of the wall pair core.
`timescale 1ns / 1ps
package wpfe_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SCALE_BITS = 15;

    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (32 + FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;
    localparam int REM_W      = 32;
    localparam int DEN_W      = 31;

    localparam int D_DIV      = DIV_STAGES;
    localparam int D_R2       = D_DIV + 2;
    localparam int D_R34      = D_DIV + 4;
    localparam int D_SAT      = D_DIV + 5;
    localparam int D_TERM     = D_DIV + 6;
    localparam int D_ADD1     = D_DIV + 7;
    localparam int D_ADD2     = D_DIV + 8;
    localparam int D_ADD3     = D_DIV + 9;
    localparam int D_FZ       = D_DIV + 11;
    localparam int D_FS       = D_DIV + 13;
    localparam int PIPE_LAST  = D_FS;
    localparam int RES_LAT    = PIPE_LAST + 2;

    localparam logic signed [63:0] Q_LIMIT   = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_ONE     = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] OUT_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] OUT_MIN   = -64'sd2147483648;
    localparam logic [30:0]        CUTOFF_RESET = 31'd163840;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORCE_COEFF_A  = 3'd0,
        REG_FORCE_COEFF_B  = 3'd1,
        REG_ENERGY_COEFF_A = 3'd2,
        REG_ENERGY_COEFF_B = 3'd3,
        REG_FORCE_SHIFT    = 3'd4,
        REG_ENERGY_SHIFT   = 3'd5,
        REG_CUTOFF_Z       = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        SH_FRAC,
        SH_SCALE
    } shift_sel_t;

    typedef struct packed {
        logic signed [31:0] delta_z;
        logic [15:0]        special_scale;
    } item_t;

    typedef struct packed {
        logic signed [31:0] force_z;
        logic signed [31:0] pair_energy;
        logic               in_range;
        logic               saturated;
    } result_t;

endpackage

>>> rtl/wall_pair_force_energy_core.sv
// Top level of the shifted-force 4-3 wall pair force and energy core.
//
// The core takes one pair per clock: an item is accepted at a rising edge with
// start high and busy low, and busy stays low, so a pair may enter every cycle.
// Each beat of the item carries the signed z separation and the Q1.15 scale.
// The result beat is shown for one cycle with done high, once through the input
// register, divider and multiply and add chain; the receiver cannot hold it off.
// The two divisions, 1/|z| and |z|/cutoff, run as a 12-stage pipeline, four
// quotient bits a stage; the multiply and clipped add chain behind them adds
// fourteen stages, each multiplier taking two. Registers are written on the cfg
// channel, one beat per cycle; the user must write them only while no pair is
// in flight, which the block does not enforce. The index selects the register
// and other indexes are ignored. Reset clears the pipeline valid bits and loads
// the coefficient registers with zero and the cutoff with 2.5 in Q16.16.
`timescale 1ns / 1ps
`include "wall_pair_force_energy_core_macros.svh"
module wall_pair_force_energy_core
    import wpfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef struct packed {
        logic                neg;
        logic                inr;
        logic                zero;
        logic [15:0]         s;
        logic [DEN_W-1:0]    den;
        logic [DIV_W-1:0]    num_i;
        logic [REM_W-1:0]    rem_i;
        logic [DIV_W-1:0]    num_t;
        logic [REM_W-1:0]    rem_t;
        logic signed [63:0]  r2inv;
        logic signed [63:0]  r3inv;
        logic signed [63:0]  r4inv;
        logic signed [63:0]  ft;
        logic signed [63:0]  et;
        logic signed [63:0]  fa;
        logic signed [63:0]  fb;
        logic signed [63:0]  ea;
        logic signed [63:0]  eb;
        logic signed [63:0]  flj;
        logic signed [63:0]  eng;
        logic signed [63:0]  fz;
        logic                c2;
        logic                c3;
        logic                c4;
        logic                sat;
        logic                clip;
    } pipe_t;

    localparam int NUM_MUL = 12;
    localparam int MI_R2 = 0;
    localparam int MI_FT = 1;
    localparam int MI_ET = 2;
    localparam int MI_R3 = 3;
    localparam int MI_R4 = 4;
    localparam int MI_FA = 5;
    localparam int MI_FB = 6;
    localparam int MI_EA = 7;
    localparam int MI_EB = 8;
    localparam int MI_FZ = 9;
    localparam int MI_ES = 10;
    localparam int MI_FS = 11;

    logic signed [31:0] force_coeff_a_reg;
    logic signed [31:0] force_coeff_b_reg;
    logic signed [31:0] energy_coeff_a_reg;
    logic signed [31:0] energy_coeff_b_reg;
    logic signed [31:0] force_shift_reg;
    logic signed [31:0] energy_shift_reg;
    logic [30:0]        cutoff_z_reg;

    logic               vld_reg  [0:PIPE_LAST];
    logic               vld_next [0:PIPE_LAST];
    pipe_t              pipe_reg  [0:PIPE_LAST];
    pipe_t              pipe_next [0:PIPE_LAST];

    logic signed [63:0] mul_a    [NUM_MUL];
    logic signed [63:0] mul_b    [NUM_MUL];
    shift_sel_t         mul_sh   [NUM_MUL];
    logic signed [63:0] mul_q    [NUM_MUL];
    logic               mul_clip [NUM_MUL];

    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;

    logic [31:0]        in_r;
    logic               in_rng;
    logic [64:0]        sum1;
    logic [64:0]        sum2;
    logic [64:0]        sum3;
    logic [64:0]        sum4;
    logic [64:0]        sum5;
    logic signed [63:0] fz_out;
    logic signed [63:0] e_out;

    function automatic logic [DIV_W+REM_W-1:0] div_step(
        input logic [DIV_W-1:0] num_in,
        input logic [REM_W-1:0] rem_in,
        input logic [DEN_W-1:0] den
    );
        logic [DIV_W-1:0] num;
        logic [REM_W-1:0] rem;
        num = num_in;
        rem = rem_in;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            rem = {rem[REM_W-2:0], num[DIV_W-1]};
            num = {num[DIV_W-2:0], 1'b0};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                num[0] = 1'b1;
            end
        end
        return {num, rem};
    endfunction

    function automatic logic [64:0] add_clip(
        input logic signed [63:0] x,
        input logic signed [63:0] y
    );
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s > $signed({Q_LIMIT[63], Q_LIMIT}))
        begin
            return {1'b1, Q_LIMIT};
        end
        else if (s < -$signed({Q_LIMIT[63], Q_LIMIT}))
        begin
            return {1'b1, -Q_LIMIT};
        end
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic signed [63:0] inv_of(input pipe_t p);
        return $signed({{(64 - DIV_W){1'b0}}, p.num_i});
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_coeff_a_reg  <= '0;
            force_coeff_b_reg  <= '0;
            energy_coeff_a_reg <= '0;
            energy_coeff_b_reg <= '0;
            force_shift_reg    <= '0;
            energy_shift_reg   <= '0;
            cutoff_z_reg       <= CUTOFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FORCE_COEFF_A:  force_coeff_a_reg  <= cfg_data;
                REG_FORCE_COEFF_B:  force_coeff_b_reg  <= cfg_data;
                REG_ENERGY_COEFF_A: energy_coeff_a_reg <= cfg_data;
                REG_ENERGY_COEFF_B: energy_coeff_b_reg <= cfg_data;
                REG_FORCE_SHIFT:    force_shift_reg    <= cfg_data;
                REG_ENERGY_SHIFT:   energy_shift_reg   <= cfg_data;
                REG_CUTOFF_Z:       cutoff_z_reg       <= cfg_data[30:0];
                default:            ;
            endcase
        end
    end

    assign in_r   = item.delta_z[31] ? (~item.delta_z + 32'd1) : item.delta_z;
    assign in_rng = in_r < {1'b0, cutoff_z_reg};

    always_comb
    begin
        vld_next[0] = start && !busy;
        for (int k = 1; k <= PIPE_LAST; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_comb
    begin
        pipe_next[0]       = '0;
        pipe_next[0].neg   = item.delta_z[31];
        pipe_next[0].inr   = in_rng;
        pipe_next[0].zero  = in_r == 32'd0;
        pipe_next[0].s     = item.special_scale;
        pipe_next[0].den   = in_r[DEN_W-1:0];
        pipe_next[0].num_i = (DIV_W'(1) << (2 * FRAC_BITS)) + DIV_W'(in_r[DEN_W-1:1]);
        pipe_next[0].num_t = (DIV_W'(in_r[DEN_W-1:0]) << FRAC_BITS)
                           + DIV_W'(cutoff_z_reg[30:1]);

        for (int k = 1; k <= PIPE_LAST; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        for (int k = 1; k <= D_DIV; k++)
        begin
            {pipe_next[k].num_i, pipe_next[k].rem_i} =
                div_step(pipe_reg[k-1].num_i, pipe_reg[k-1].rem_i, pipe_reg[k-1].den);
            {pipe_next[k].num_t, pipe_next[k].rem_t} =
                div_step(pipe_reg[k-1].num_t, pipe_reg[k-1].rem_t, cutoff_z_reg);
        end

        pipe_next[D_R2].r2inv = mul_q[MI_R2];
        pipe_next[D_R2].c2    = mul_clip[MI_R2];
        pipe_next[D_R2].ft    = mul_q[MI_FT];
        pipe_next[D_R2].et    = mul_q[MI_ET];
        pipe_next[D_R2].clip  = pipe_reg[D_R2-1].clip | mul_clip[MI_FT] | mul_clip[MI_ET];

        pipe_next[D_R34].r3inv = mul_q[MI_R3];
        pipe_next[D_R34].r4inv = mul_q[MI_R4];
        pipe_next[D_R34].c3    = mul_clip[MI_R3] | pipe_reg[D_R34-1].c2;
        pipe_next[D_R34].c4    = mul_clip[MI_R4] | pipe_reg[D_R34-1].c2;

        pipe_next[D_SAT].sat =
            (pipe_reg[D_SAT-1].c4 && force_coeff_a_reg != 32'sd0)
            || (pipe_reg[D_SAT-1].c3 && force_coeff_b_reg != 32'sd0)
            || (pipe_reg[D_SAT-1].c4 && energy_coeff_a_reg != 32'sd0)
            || (pipe_reg[D_SAT-1].c3 && energy_coeff_b_reg != 32'sd0);

        pipe_next[D_TERM].fa   = mul_q[MI_FA];
        pipe_next[D_TERM].fb   = mul_q[MI_FB];
        pipe_next[D_TERM].ea   = mul_q[MI_EA];
        pipe_next[D_TERM].eb   = mul_q[MI_EB];
        pipe_next[D_TERM].clip = pipe_reg[D_TERM-1].clip | mul_clip[MI_FA]
                               | mul_clip[MI_FB] | mul_clip[MI_EA] | mul_clip[MI_EB];

        sum1 = add_clip(pipe_reg[D_ADD1-1].fa, -pipe_reg[D_ADD1-1].fb);
        sum2 = add_clip(pipe_reg[D_ADD1-1].ea, -pipe_reg[D_ADD1-1].eb);
        pipe_next[D_ADD1].flj  = sum1[63:0];
        pipe_next[D_ADD1].eng  = sum2[63:0];
        pipe_next[D_ADD1].clip = pipe_reg[D_ADD1-1].clip | sum1[64] | sum2[64];

        sum3 = add_clip(pipe_reg[D_ADD2-1].flj, -pipe_reg[D_ADD2-1].ft);
        sum4 = add_clip(pipe_reg[D_ADD2-1].eng, pipe_reg[D_ADD2-1].et);
        pipe_next[D_ADD2].flj  = sum3[63:0];
        pipe_next[D_ADD2].eng  = sum4[63:0];
        pipe_next[D_ADD2].clip = pipe_reg[D_ADD2-1].clip | sum3[64] | sum4[64];

        sum5 = add_clip(pipe_reg[D_ADD3-1].eng, -64'(energy_shift_reg));
        pipe_next[D_ADD3].eng  = sum5[63:0];
        pipe_next[D_ADD3].clip = pipe_reg[D_ADD3-1].clip | sum5[64];

        pipe_next[D_FZ].fz   = mul_q[MI_FZ];
        pipe_next[D_FZ].eng  = mul_q[MI_ES];
        pipe_next[D_FZ].clip = pipe_reg[D_FZ-1].clip | mul_clip[MI_FZ] | mul_clip[MI_ES];

        pipe_next[D_FS].fz   = mul_q[MI_FS];
        pipe_next[D_FS].clip = pipe_reg[D_FS-1].clip | mul_clip[MI_FS];
    end

    always_comb
    begin
        mul_a[MI_R2]  = inv_of(pipe_reg[D_DIV]);
        mul_b[MI_R2]  = inv_of(pipe_reg[D_DIV]);
        mul_sh[MI_R2] = SH_FRAC;
        mul_a[MI_FT]  = $signed({{(64 - DIV_W){1'b0}}, pipe_reg[D_DIV].num_t});
        mul_b[MI_FT]  = 64'(force_shift_reg);
        mul_sh[MI_FT] = SH_FRAC;
        mul_a[MI_ET]  = $signed({{(64 - DIV_W){1'b0}}, pipe_reg[D_DIV].num_t}) - Q_ONE;
        mul_b[MI_ET]  = 64'(force_shift_reg);
        mul_sh[MI_ET] = SH_FRAC;

        mul_a[MI_R3]  = pipe_reg[D_R2].r2inv;
        mul_b[MI_R3]  = inv_of(pipe_reg[D_R2]);
        mul_sh[MI_R3] = SH_FRAC;
        mul_a[MI_R4]  = pipe_reg[D_R2].r2inv;
        mul_b[MI_R4]  = pipe_reg[D_R2].r2inv;
        mul_sh[MI_R4] = SH_FRAC;

        mul_a[MI_FA]  = 64'(force_coeff_a_reg);
        mul_b[MI_FA]  = pipe_reg[D_R34].r4inv;
        mul_sh[MI_FA] = SH_FRAC;
        mul_a[MI_FB]  = 64'(force_coeff_b_reg);
        mul_b[MI_FB]  = pipe_reg[D_R34].r3inv;
        mul_sh[MI_FB] = SH_FRAC;
        mul_a[MI_EA]  = 64'(energy_coeff_a_reg);
        mul_b[MI_EA]  = pipe_reg[D_R34].r4inv;
        mul_sh[MI_EA] = SH_FRAC;
        mul_a[MI_EB]  = 64'(energy_coeff_b_reg);
        mul_b[MI_EB]  = pipe_reg[D_R34].r3inv;
        mul_sh[MI_EB] = SH_FRAC;

        mul_a[MI_FZ]  = pipe_reg[D_ADD3].flj;
        mul_b[MI_FZ]  = inv_of(pipe_reg[D_ADD3]);
        mul_sh[MI_FZ] = SH_FRAC;
        mul_a[MI_ES]  = pipe_reg[D_ADD3].eng;
        mul_b[MI_ES]  = $signed({48'd0, pipe_reg[D_ADD3].s});
        mul_sh[MI_ES] = SH_SCALE;

        mul_a[MI_FS]  = pipe_reg[D_FZ].fz;
        mul_b[MI_FS]  = $signed({48'd0, pipe_reg[D_FZ].s});
        mul_sh[MI_FS] = SH_SCALE;
    end

    for (genvar g = 0; g < NUM_MUL; g++)
    begin : g_mul
        wpfe_mul u_mul (
            .clk  (clk),
            .a    (mul_a[g]),
            .b    (mul_b[g]),
            .sh   (mul_sh[g]),
            .q    (mul_q[g]),
            .clip (mul_clip[g])
        );
    end

    always_comb
    begin
        fz_out = pipe_reg[PIPE_LAST].neg ? -pipe_reg[PIPE_LAST].fz : pipe_reg[PIPE_LAST].fz;
        e_out  = pipe_reg[PIPE_LAST].eng;
        result_next.in_range  = 1'b1;
        result_next.saturated = pipe_reg[PIPE_LAST].sat | pipe_reg[PIPE_LAST].clip;
        if (fz_out > OUT_MAX)
        begin
            result_next.force_z   = OUT_MAX[31:0];
            result_next.saturated = 1'b1;
        end
        else if (fz_out < OUT_MIN)
        begin
            result_next.force_z   = OUT_MIN[31:0];
            result_next.saturated = 1'b1;
        end
        else
        begin
            result_next.force_z = fz_out[31:0];
        end
        if (e_out > OUT_MAX)
        begin
            result_next.pair_energy = OUT_MAX[31:0];
            result_next.saturated   = 1'b1;
        end
        else if (e_out < OUT_MIN)
        begin
            result_next.pair_energy = OUT_MIN[31:0];
            result_next.saturated   = 1'b1;
        end
        else
        begin
            result_next.pair_energy = e_out[31:0];
        end
        if (!pipe_reg[PIPE_LAST].inr)
        begin
            result_next = '0;
        end
        else if (pipe_reg[PIPE_LAST].zero)
        begin
            result_next.force_z     = '0;
            result_next.pair_energy = OUT_MAX[31:0];
            result_next.in_range    = 1'b1;
            result_next.saturated   = 1'b1;
        end
        done_next = vld_reg[PIPE_LAST];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= PIPE_LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k <= PIPE_LAST; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= PIPE_LAST; k++)
        begin
            pipe_reg[k] <= pipe_next[k];
        end
        result_reg <= result_next;
    end

    `WPFE_ASSERT_AFTER(a_latency, start && !busy, RES_LAT, done, "accepted pair gave no result")
    `WPFE_ASSERT_NOW(a_out_of_range_zero, done && !result.in_range,
        result.force_z == 32'sd0 && result.pair_energy == 32'sd0 && !result.saturated,
        "out-of-range result not zero")
    `WPFE_ASSERT_NOW(a_range_flag, done, result.in_range == $past(in_rng, RES_LAT),
        "range flag does not match the accepted separation")

endmodule

>>> rtl/wpfe_mul.sv
// Signed multiplier with registered partials, round-half-away shift, Q limit clip.
`timescale 1ns / 1ps
module wpfe_mul
    import wpfe_pkg::*;
(
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  shift_sel_t         sh,
    output logic signed [63:0] q,
    output logic               clip
);

    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [63:0]  pp_ll_reg;
    logic [63:0]  pp_lh_reg;
    logic [63:0]  pp_hl_reg;
    logic [63:0]  pp_hh_reg;
    logic         neg_reg;
    shift_sel_t   sh_reg;
    logic [127:0] prod;
    logic [127:0] rounded;
    logic [127:0] q_full;
    logic [63:0]  mag_q;

    assign mag_a = a[63] ? (~a + 64'd1) : a;
    assign mag_b = b[63] ? (~b + 64'd1) : b;

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= mag_a[31:0]  * mag_b[31:0];
        pp_lh_reg <= mag_a[31:0]  * mag_b[63:32];
        pp_hl_reg <= mag_a[63:32] * mag_b[31:0];
        pp_hh_reg <= mag_a[63:32] * mag_b[63:32];
        neg_reg   <= a[63] ^ b[63];
        sh_reg    <= sh;
    end

    always_comb
    begin
        prod = {pp_hh_reg, pp_ll_reg} + ({64'd0, pp_lh_reg} << 32)
             + ({64'd0, pp_hl_reg} << 32);
        if (sh_reg == SH_FRAC)
        begin
            rounded = prod + (128'd1 << (FRAC_BITS - 1));
            q_full  = rounded >> FRAC_BITS;
        end
        else
        begin
            rounded = prod + (128'd1 << (SCALE_BITS - 1));
            q_full  = rounded >> SCALE_BITS;
        end
        clip  = |q_full[127:62];
        mag_q = clip ? Q_LIMIT : {2'b00, q_full[61:0]};
        q     = neg_reg ? -$signed(mag_q) : $signed(mag_q);
    end

endmodule
